@@ rtl/bblf_pkg.sv @@
// ----------------------------------------------------------------------------
// bblf_pkg: shared constants and types for the box blur line filter
// Widths of the pixel store, running sums, reciprocal multiply and lane control.
// ----------------------------------------------------------------------------
package bblf_pkg;

	// Largest radius the window store is sized for
	localparam int unsigned MAX_RADIUS  = 31;
	localparam int unsigned STORE_DEPTH = 2 * MAX_RADIUS + 2;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned POS_LIMIT   = 2 * MAX_RADIUS + 1;
	localparam int unsigned POS_W       = $clog2(POS_LIMIT + 1);
	localparam int unsigned WIN_W       = $clog2(2 * MAX_RADIUS + 2);

	// Register and channel widths
	localparam int unsigned RAD_W   = 5;
	localparam int unsigned RAD_CNT = 2 ** RAD_W;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned NUM_CH  = 4;
	localparam int unsigned PIX_W   = CH_W * NUM_CH;

	// Window sum: up to (2*MAX_RADIUS+1) * 255
	localparam int unsigned SUM_W = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);

	// Division by window width as multiply by ceil(2^RCP_SHIFT / w)
	localparam int unsigned RCP_SHIFT = SUM_W + WIN_W + 1;
	localparam int unsigned RCP_W     = RCP_SHIFT + 1;
	localparam int unsigned PROD_W    = SUM_W + RCP_W;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Per-step control shared by all four lanes
	typedef struct packed {
		logic init;   // first pixel of a line: sum = w * pixel
		logic slide;  // sum += entering - leaving
		logic mul;    // product = sum * reciprocal
	} lane_ctrl_t;

endpackage

@@ rtl/bblf_store.sv @@
// ----------------------------------------------------------------------------
// bblf_store: window pixel memory
// Circular buffer of recent pixels, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module bblf_store (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [bblf_pkg::ADDR_W-1:0] wr_addr,
	input  bblf_pkg::pixel_t       wr_data,
	input  logic                   rd_en,
	input  logic [bblf_pkg::ADDR_W-1:0] rd_addr,
	output bblf_pkg::pixel_t       rd_data
);
	import bblf_pkg::*;

	pixel_t mem_q [STORE_DEPTH];
	pixel_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/bblf_lane.sv @@
// ----------------------------------------------------------------------------
// bblf_lane: one colour channel of the blur
// Running window sum and its product with the window reciprocal.
// ----------------------------------------------------------------------------
module bblf_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bblf_pkg::lane_ctrl_t   ctrl,
	input  logic [bblf_pkg::WIN_W-1:0] win,
	input  logic [bblf_pkg::RCP_W-1:0] rcp,
	input  bblf_pkg::chan_t        enter_ch,
	input  bblf_pkg::chan_t        leave_ch,
	output bblf_pkg::prod_t        prod
);
	import bblf_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] init_sum;
	logic [SUM_W-1:0] slide_sum;
	prod_t            prod_q;

	// Start value and sliding update; the true sum never leaves range
	assign init_sum  = SUM_W'(win) * SUM_W'(enter_ch);
	assign slide_sum = sum_q + SUM_W'(enter_ch) - SUM_W'(leave_ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.init) begin
			sum_q <= init_sum;
		end else if (ctrl.slide) begin
			sum_q <= slide_sum;
		end
	end

	// Reciprocal multiply, registered before the merge stage
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= PROD_W'(sum_q) * PROD_W'(rcp);
		end
	end

	assign prod = prod_q;

endmodule

@@ rtl/bblf_merge.sv @@
// ----------------------------------------------------------------------------
// bblf_merge: output stage
// Gathers the four lane quotients into one result item and holds it on stall.
// ----------------------------------------------------------------------------
module bblf_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  bblf_pkg::prod_t prod [bblf_pkg::NUM_CH],
	input  logic            line_end,
	input  logic            out_stall,
	output logic            free,
	output logic            out_valid,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out,
	output logic [7:0]      alpha_out,
	output logic            line_end_out
);
	import bblf_pkg::*;

	logic  valid_q;
	chan_t mean_q [NUM_CH];
	logic  line_end_q;

	// Register can take a new item when empty or being drained
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Quotient is the product shifted down by the reciprocal scale
	always_ff @(posedge clk) begin
		if (load) begin
			for (int c = 0; c < NUM_CH; c++) begin
				mean_q[c] <= prod[c][RCP_SHIFT +: CH_W];
			end
			line_end_q <= line_end;
		end
	end

	assign out_valid    = valid_q;
	assign red_out      = mean_q[0];
	assign green_out    = mean_q[1];
	assign blue_out     = mean_q[2];
	assign alpha_out    = mean_q[3];
	assign line_end_out = line_end_q;

endmodule

@@ rtl/box_blur_line_filter.sv @@
// ----------------------------------------------------------------------------
// box_blur_line_filter: one-axis box blur with clamped line ends
// Four channel lanes keep running window sums; a sequencer walks each pixel
// and the tail of each line, and a merge stage forms the result items.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------
//   in      | in_valid / in_stall     | red/green/blue/alpha_in, line_end_in
//   out     | out_valid / out_stall   | red/green/blue/alpha_out, line_end_out
//   cfg     | cfg_wr_en               | cfg_wr_data (radius)
//
// An ordinary pixel passes accept, slide, multiply and emit, or accept and
// slide alone when it gives no result. A line-end pixel then walks the tail
// of the line, with a slide step per tail position and multiply and emit for
// each emitting one. A full output register holds the sequencer in its emit
// step. Reset clears the radius to 1 and starts a new line; the pixel store
// is not cleared. A radius write starts a new line.
// ----------------------------------------------------------------------------
module box_blur_line_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	input  logic       line_end_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [7:0] alpha_out,
	output logic       line_end_out
);
	import bblf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SLIDE,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [RAD_W-1:0]  radius_q;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] cur_addr_q;
	pixel_t            pix_q;
	pixel_t            first_q;
	logic [POS_W-1:0]  n_q;
	logic              last_q;
	logic [RAD_W-1:0]  t_q;
	logic [WIN_W-1:0]  dist_q;

	logic              accept;
	pixel_t            pix_in;
	logic [WIN_W-1:0]  win;
	logic [RCP_W-1:0]  rcp_tab [RAD_CNT];
	logic [RCP_W-1:0]  rcp;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	pixel_t            rd_data;
	pixel_t            leave_pix;
	logic              emit;
	logic              more;
	logic              step_next;
	lane_ctrl_t        lane_ctrl;
	prod_t             prod [NUM_CH];
	logic              merge_free;
	logic              merge_load;

	// Window reciprocals, one per radius
	for (genvar g = 0; g < RAD_CNT; g++) begin : g_rcp
		localparam int unsigned WG    = 2 * g + 1;
		localparam int unsigned RCP_G = ((1 << RCP_SHIFT) + WG - 1) / WG;
		assign rcp_tab[g] = RCP_W'(RCP_G);
	end

	assign win    = {radius_q, 1'b1};
	assign rcp    = rcp_tab[radius_q];
	assign pix_in = {alpha_in, blue_in, green_in, red_in};

	// Input handshake
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Step decisions
	assign emit = ({1'b0, n_q} + (POS_W + 1)'(t_q)) >= (POS_W + 1)'(radius_q);
	assign more = last_q && (t_q != radius_q);
	assign merge_load = (state_q == ST_EMIT) && merge_free;
	assign step_next  = more && (((state_q == ST_SLIDE) && !emit) || merge_load);

	// Store read: pixel w back on accept, one nearer each tail step
	always_comb begin
		rd_en   = accept || step_next;
		rd_addr = cur_addr_q - ADDR_W'(dist_q - 1'b1);
		if (state_q == ST_IDLE) begin
			rd_addr = wp_q - ADDR_W'(win);
		end
	end

	// Leaving pixel, clamped to the first pixel before the line start
	assign leave_pix = (n_q >= POS_W'(dist_q)) ? rd_data : first_q;

	assign lane_ctrl.init  = (state_q == ST_SLIDE) && (n_q == '0) && (t_q == '0);
	assign lane_ctrl.slide = (state_q == ST_SLIDE) && !lane_ctrl.init;
	assign lane_ctrl.mul   = (state_q == ST_MUL);

	// Sequencer and line bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			radius_q <= RAD_W'(1);
			pos_q    <= '0;
			wp_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				radius_q <= (cfg_wr_data > RAD_W'(MAX_RADIUS)) ?
					RAD_W'(MAX_RADIUS) : cfg_wr_data;
				pos_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_addr_q <= wp_q;
						wp_q       <= wp_q + 1'b1;
						pix_q      <= pix_in;
						n_q        <= pos_q;
						last_q     <= line_end_in;
						t_q        <= '0;
						dist_q     <= win;
						if (pos_q == '0) begin
							first_q <= pix_in;
						end
						if (line_end_in) begin
							pos_q <= '0;
						end else if (pos_q != POS_W'(POS_LIMIT)) begin
							pos_q <= pos_q + 1'b1;
						end
						state_q <= ST_SLIDE;
					end
				end
				ST_SLIDE: begin
					if (emit) begin
						state_q <= ST_MUL;
					end else if (more) begin
						t_q    <= t_q + 1'b1;
						dist_q <= dist_q - 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (merge_load) begin
						if (more) begin
							t_q     <= t_q + 1'b1;
							dist_q  <= dist_q - 1'b1;
							state_q <= ST_SLIDE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	bblf_store u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wp_q),
		.wr_data (pix_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// One lane per colour channel
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		bblf_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (lane_ctrl),
			.win      (win),
			.rcp      (rcp),
			.enter_ch (pix_q[c*CH_W +: CH_W]),
			.leave_ch (leave_pix[c*CH_W +: CH_W]),
			.prod     (prod[c])
		);
	end

	bblf_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (merge_load),
		.prod         (prod),
		.line_end     (last_q && (t_q == radius_q)),
		.out_stall    (out_stall),
		.free         (merge_free),
		.out_valid    (out_valid),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.alpha_out    (alpha_out),
		.line_end_out (line_end_out)
	);

`ifndef SYNTHESIS
	// Tail counter never passes the radius
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (t_q <= radius_q))
		else $error("tail step beyond radius");

	// Read distance and tail step always add up to the window width
	a_dist_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((WIN_W + 1)'(dist_q) + (WIN_W + 1)'(t_q) ==
		(WIN_W + 1)'(win)))
		else $error("read distance out of step");

	// Multiply is always followed by the emit step
	a_mul_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_EMIT))
		else $error("multiply not followed by emit");

	// A line-end result only goes out once the line position is cleared
	a_line_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(merge_load && last_q && (t_q == radius_q)) |-> (pos_q == '0))
		else $error("line end emitted with open line");
`endif

endmodule
